/* rtl/assert_macros.svh */
// Assertion macros used by the top level of the path planner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle implication failed");

`endif

/* rtl/gapp_pkg.sv */
// Package with shared types, codes and defaults of the grid path planner.
package gapp_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_HEAP_DEPTH = 4096;

    localparam int GRID_REG_W = 7;
    localparam int COORD_W    = 6;
    localparam int STEP_W     = 12;
    localparam int PLEN_W     = 13;
    localparam int STATUS_W   = 3;
    localparam int REQ_W      = 2;

    localparam logic [REQ_W-1:0] REQ_WRITE_MAP = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PLAN      = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ_STEP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BOUNDS    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BLOCKED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_PATH   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_HEAP_FULL = 3'd4;

    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] goal_x;
        logic [COORD_W-1:0] goal_y;
        logic               cell_open;
        logic [STEP_W-1:0]  step_index;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PLEN_W-1:0]   path_length;
        logic [COORD_W-1:0]  step_x;
        logic [COORD_W-1:0]  step_y;
    } rsp_t;

endpackage

/* rtl/gapp_ram.sv */
// Simple dual-port synchronous RAM with one write and one registered read port.
module gapp_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/grid_astar_path_planner.sv */
// Top level of the grid path planner: request sequencer, heap and cell memories.
//
//  channel | handshake            | payload             | direction
//  --------+----------------------+---------------------+----------
//  request | req_valid/req_ready  | req (req_t)         | in
//  result  | rsp_valid/rsp_ready  | rsp (rsp_t)         | out
//  config  | cfg_valid/cfg_ready  | cfg_index, cfg_data | in
//
// A map write or an ignored request goes from idle straight to the result state; a step
// read passes through a read state first. A plan first sweeps the cost memory, one cell
// a cycle, to mark every cost unknown. Each pop, each heap level a key sinks, each
// neighbor test, each push and each level a key rises is then worked in states of its
// own, as the heap memory has a single read port.
// After reset the map memory is cleared, one cell a cycle, and no request is taken
// meanwhile; configuration is always taken.
// One request is worked at a time; a finished result waits in the output
// register, and the sequencer stalls only if a second result is ready first.
module grid_astar_path_planner #(
    parameter int MAX_WIDTH  = gapp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gapp_pkg::DEF_MAX_HEIGHT,
    parameter int HEAP_DEPTH = gapp_pkg::DEF_HEAP_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  gapp_pkg::req_t                    req,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output gapp_pkg::rsp_t                    rsp,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [gapp_pkg::GRID_REG_W-1:0]   cfg_data
);

    `include "assert_macros.svh"

    // Cells are addressed as {row, column}; this keeps the tie order of the
    // linear index and needs no multiply.
    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int YW     = $clog2(MAX_HEIGHT);
    localparam int CW     = XW + YW;
    localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
    localparam int G_W    = $clog2(CELLS + MAX_WIDTH + MAX_HEIGHT);
    localparam int KEY_W  = 2 * G_W + CW;
    localparam int HA     = $clog2(HEAP_DEPTH);
    localparam int HC_W   = $clog2(HEAP_DEPTH + 1);
    localparam int LEN_W  = $clog2(CELLS + 1);
    localparam int DIM_W  = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 130);
    localparam int KC_W   = (LEN_W > gapp_pkg::STEP_W) ? LEN_W : gapp_pkg::STEP_W;
    localparam int CM_W   = G_W + CW;

    localparam logic [4:0] S_RST_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_RD_STEP  = 5'd2;
    localparam logic [4:0] S_CHK_GOAL = 5'd3;
    localparam logic [4:0] S_CLR      = 5'd4;
    localparam logic [4:0] S_INIT     = 5'd5;
    localparam logic [4:0] S_POP      = 5'd6;
    localparam logic [4:0] S_POP_TOP  = 5'd7;
    localparam logic [4:0] S_POP_LAST = 5'd8;
    localparam logic [4:0] S_SD_CHK   = 5'd9;
    localparam logic [4:0] S_SD_R1    = 5'd10;
    localparam logic [4:0] S_SD_R2    = 5'd11;
    localparam logic [4:0] S_SD_CMP   = 5'd12;
    localparam logic [4:0] S_SD_END   = 5'd13;
    localparam logic [4:0] S_EXP0     = 5'd14;
    localparam logic [4:0] S_EXP1     = 5'd15;
    localparam logic [4:0] S_NB       = 5'd16;
    localparam logic [4:0] S_NB_CHK   = 5'd17;
    localparam logic [4:0] S_SU_CHK   = 5'd18;
    localparam logic [4:0] S_SU_CMP   = 5'd19;
    localparam logic [4:0] S_SU_END   = 5'd20;
    localparam logic [4:0] S_BT0      = 5'd21;
    localparam logic [4:0] S_BT1      = 5'd22;
    localparam logic [4:0] S_BT2      = 5'd23;
    localparam logic [4:0] S_DONE     = 5'd24;

    logic [4:0]                     state_reg, state_next;
    logic [CW-1:0]                  clr_addr_reg, clr_addr_next;
    logic [gapp_pkg::GRID_REG_W-1:0] gw_cfg_reg, gh_cfg_reg;
    logic [LEN_W-1:0]               stored_len_reg, stored_len_next;
    logic [HC_W-1:0]                heap_cnt_reg, heap_cnt_next;
    logic [CW-1:0]                  s_cell_reg, s_cell_next;
    logic [CW-1:0]                  t_cell_reg, t_cell_next;
    logic [CW-1:0]                  cur_reg, cur_next;
    logic [G_W-1:0]                 cur_g_reg, cur_g_next;
    logic [1:0]                     dir_reg, dir_next;
    logic [CW-1:0]                  nb_reg, nb_next;
    logic [KEY_W-1:0]               last_reg, last_next;
    logic [KEY_W-1:0]               cval_reg, cval_next;
    logic [KEY_W-1:0]               key_reg, key_next;
    logic [HA-1:0]                  idx_reg, idx_next;
    logic [HA-1:0]                  child_reg, child_next;
    logic [LEN_W-1:0]               k_reg, k_next;
    logic [LEN_W-1:0]               len_reg, len_next;
    logic [CW-1:0]                  p_reg, p_next;
    gapp_pkg::rsp_t                 pend_reg, pend_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    gapp_pkg::rsp_t                 rsp_reg, rsp_next;

    // Memory ports.
    logic             occ_we, occ_wdata, occ_rdata;
    logic [CW-1:0]    occ_waddr, occ_raddr;
    logic             cm_we;
    logic [CW-1:0]    cm_waddr, cm_raddr;
    logic [CM_W-1:0]  cm_wdata, cm_rdata;
    logic             hp_we;
    logic [HA-1:0]    hp_waddr, hp_raddr;
    logic [KEY_W-1:0] hp_wdata, hp_rdata;
    logic             pa_we;
    logic [CW-1:0]    pa_waddr, pa_raddr, pa_wdata, pa_rdata;

    // Effective grid size and helpers.
    logic [DIM_W-1:0] gw_eff, gh_eff;
    logic [G_W-1:0]   cm_cost;
    logic [CW-1:0]    cm_came;
    logic [XW-1:0]    cur_x, nb_x, t_x;
    logic [YW-1:0]    cur_y, nb_y, t_y;
    logic             nb_ok;
    logic [G_W-1:0]   ng;
    logic [HA:0]      sd_child;
    logic [KEY_W-1:0] top_key;

    function automatic logic [DIM_W-1:0] adiff(input logic [DIM_W-1:0] a,
                                               input logic [DIM_W-1:0] b);
        adiff = (a > b) ? (a - b) : (b - a);
    endfunction

    assign gw_eff = (DIM_W'(gw_cfg_reg) > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                            : DIM_W'(gw_cfg_reg);
    assign gh_eff = (DIM_W'(gh_cfg_reg) > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                             : DIM_W'(gh_cfg_reg);
    assign cm_cost = cm_rdata[CM_W-1:CW];
    assign cm_came = cm_rdata[CW-1:0];
    assign cur_x   = cur_reg[XW-1:0];
    assign cur_y   = cur_reg[CW-1:XW];
    assign t_x     = t_cell_reg[XW-1:0];
    assign t_y     = t_cell_reg[CW-1:XW];
    assign ng      = cur_g_reg + G_W'(1);
    assign sd_child = {idx_reg, 1'b1};
    assign top_key = hp_rdata;

    // Neighbor of the current cell in direction dir_reg: +x, -x, +y, -y.
    always_comb
    begin
        nb_x  = cur_x;
        nb_y  = cur_y;
        nb_ok = 1'b0;
        case (dir_reg)
            2'd0:
            begin
                nb_ok = (DIM_W'(cur_x) + DIM_W'(1)) < gw_eff;
                nb_x  = cur_x + XW'(1);
            end
            2'd1:
            begin
                nb_ok = (cur_x != '0);
                nb_x  = cur_x - XW'(1);
            end
            2'd2:
            begin
                nb_ok = (DIM_W'(cur_y) + DIM_W'(1)) < gh_eff;
                nb_y  = cur_y + YW'(1);
            end
            default:
            begin
                nb_ok = (cur_y != '0);
                nb_y  = cur_y - YW'(1);
            end
        endcase
    end

    always_comb
    begin
        logic             in_bounds;
        logic [CW-1:0]    s_in, t_in;
        logic [DIM_W-1:0] h;

        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        stored_len_next = stored_len_reg;
        heap_cnt_next   = heap_cnt_reg;
        s_cell_next     = s_cell_reg;
        t_cell_next     = t_cell_reg;
        cur_next        = cur_reg;
        cur_g_next      = cur_g_reg;
        dir_next        = dir_reg;
        nb_next         = nb_reg;
        last_next       = last_reg;
        cval_next       = cval_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        child_next      = child_reg;
        k_next          = k_reg;
        len_next        = len_reg;
        p_next          = p_reg;
        pend_next       = pend_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_next        = rsp_reg;

        occ_we = 1'b0; occ_waddr = clr_addr_reg; occ_wdata = 1'b0; occ_raddr = t_cell_reg;
        cm_we  = 1'b0; cm_waddr = clr_addr_reg; cm_wdata = '1; cm_raddr = cur_reg;
        hp_we  = 1'b0; hp_waddr = idx_reg; hp_wdata = key_reg; hp_raddr = '0;
        pa_we  = 1'b0; pa_waddr = k_reg[CW-1:0]; pa_wdata = p_reg;
        pa_raddr = CW'(req.step_index);

        s_in = {YW'(req.cell_y), XW'(req.cell_x)};
        t_in = {YW'(req.goal_y), XW'(req.goal_x)};
        in_bounds = (DIM_W'(req.cell_x) < gw_eff) && (DIM_W'(req.cell_y) < gh_eff)
                 && (DIM_W'(req.goal_x) < gw_eff) && (DIM_W'(req.goal_y) < gh_eff);
        h = adiff(DIM_W'(nb_x), DIM_W'(t_x)) + adiff(DIM_W'(nb_y), DIM_W'(t_y));

        case (state_reg)
            S_RST_CLR:
            begin
                occ_we = 1'b1;
                clr_addr_next = clr_addr_reg + CW'(1);
                if (&clr_addr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    pend_next = '{status: gapp_pkg::ST_OK,
                                  path_length: gapp_pkg::PLEN_W'(stored_len_reg),
                                  step_x: '0, step_y: '0};
                    state_next = S_DONE;
                    case (req.req_type)
                        gapp_pkg::REQ_WRITE_MAP:
                        begin
                            if ((DIM_W'(req.cell_x) < DIM_W'(MAX_WIDTH)) &&
                                (DIM_W'(req.cell_y) < DIM_W'(MAX_HEIGHT)))
                            begin
                                occ_we    = 1'b1;
                                occ_waddr = s_in;
                                occ_wdata = req.cell_open;
                            end
                        end
                        gapp_pkg::REQ_PLAN:
                        begin
                            pend_next.path_length = '0;
                            if (!in_bounds)
                            begin
                                pend_next.status = gapp_pkg::ST_BOUNDS;
                            end
                            else
                            begin
                                s_cell_next = s_in;
                                t_cell_next = t_in;
                                occ_raddr   = t_in;
                                state_next  = S_CHK_GOAL;
                            end
                        end
                        gapp_pkg::REQ_READ_STEP:
                        begin
                            if (KC_W'(req.step_index) < KC_W'(stored_len_reg))
                            begin
                                state_next = S_RD_STEP;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RD_STEP:
            begin
                pend_next.step_x = gapp_pkg::COORD_W'(pa_rdata[XW-1:0]);
                pend_next.step_y = gapp_pkg::COORD_W'(pa_rdata[CW-1:XW]);
                state_next = S_DONE;
            end
            S_CHK_GOAL:
            begin
                if (!occ_rdata && (s_cell_reg != t_cell_reg))
                begin
                    pend_next.status = gapp_pkg::ST_BLOCKED;
                    state_next = S_DONE;
                end
                else
                begin
                    clr_addr_next = '0;
                    state_next = S_CLR;
                end
            end
            S_CLR:
            begin
                cm_we = 1'b1;
                clr_addr_next = clr_addr_reg + CW'(1);
                if (&clr_addr_reg)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cm_we    = 1'b1;
                cm_waddr = s_cell_reg;
                cm_wdata = {G_W'(0), s_cell_reg};
                hp_we    = 1'b1;
                hp_waddr = '0;
                hp_wdata = {G_W'(adiff(DIM_W'(s_cell_reg[XW-1:0]), DIM_W'(t_x))
                                + adiff(DIM_W'(s_cell_reg[CW-1:XW]), DIM_W'(t_y))),
                            G_W'(0), s_cell_reg};
                heap_cnt_next = HC_W'(1);
                state_next = S_POP;
            end
            S_POP:
            begin
                if (heap_cnt_reg == '0)
                begin
                    pend_next.status = gapp_pkg::ST_NO_PATH;
                    state_next = S_DONE;
                end
                else
                begin
                    hp_raddr = '0;
                    state_next = S_POP_TOP;
                end
            end
            S_POP_TOP:
            begin
                cur_next      = top_key[CW-1:0];
                cur_g_next    = top_key[CW+G_W-1:CW];
                hp_raddr      = HA'(heap_cnt_reg - HC_W'(1));
                heap_cnt_next = heap_cnt_reg - HC_W'(1);
                state_next    = S_POP_LAST;
            end
            S_POP_LAST:
            begin
                last_next  = hp_rdata;
                idx_next   = '0;
                state_next = S_SD_CHK;
            end
            S_SD_CHK:
            begin
                if (sd_child >= (HA + 1)'(heap_cnt_reg))
                begin
                    state_next = S_SD_END;
                end
                else
                begin
                    hp_raddr   = sd_child[HA-1:0];
                    child_next = sd_child[HA-1:0];
                    state_next = S_SD_R1;
                end
            end
            S_SD_R1:
            begin
                cval_next = hp_rdata;
                if ((HC_W + 1)'(child_reg) + (HC_W + 1)'(1) < (HC_W + 1)'(heap_cnt_reg))
                begin
                    hp_raddr   = child_reg + HA'(1);
                    state_next = S_SD_R2;
                end
                else
                begin
                    state_next = S_SD_CMP;
                end
            end
            S_SD_R2:
            begin
                if (hp_rdata < cval_reg)
                begin
                    cval_next  = hp_rdata;
                    child_next = child_reg + HA'(1);
                end
                state_next = S_SD_CMP;
            end
            S_SD_CMP:
            begin
                if (last_reg <= cval_reg)
                begin
                    state_next = S_SD_END;
                end
                else
                begin
                    hp_we      = 1'b1;
                    hp_wdata   = cval_reg;
                    idx_next   = child_reg;
                    state_next = S_SD_CHK;
                end
            end
            S_SD_END:
            begin
                if (heap_cnt_reg != '0)
                begin
                    hp_we    = 1'b1;
                    hp_wdata = last_reg;
                end
                state_next = S_EXP0;
            end
            S_EXP0:
            begin
                if (cur_reg == t_cell_reg)
                begin
                    cm_raddr   = t_cell_reg;
                    state_next = S_BT0;
                end
                else
                begin
                    cm_raddr   = cur_reg;
                    state_next = S_EXP1;
                end
            end
            S_EXP1:
            begin
                if (cur_g_reg > cm_cost)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    cur_g_next = cm_cost;
                    dir_next   = 2'd0;
                    state_next = S_NB;
                end
            end
            S_NB:
            begin
                if (nb_ok)
                begin
                    occ_raddr  = {nb_y, nb_x};
                    cm_raddr   = {nb_y, nb_x};
                    nb_next    = {nb_y, nb_x};
                    key_next   = {G_W'(ng + G_W'(h)), ng, nb_y, nb_x};
                    state_next = S_NB_CHK;
                end
                else if (dir_reg == 2'd3)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    dir_next = dir_reg + 2'd1;
                end
            end
            S_NB_CHK:
            begin
                if ((occ_rdata || (nb_reg == t_cell_reg)) && (ng < cm_cost))
                begin
                    cm_we    = 1'b1;
                    cm_waddr = nb_reg;
                    cm_wdata = {ng, cur_reg};
                    if (heap_cnt_reg >= HC_W'(HEAP_DEPTH))
                    begin
                        pend_next.status = gapp_pkg::ST_HEAP_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next      = HA'(heap_cnt_reg);
                        heap_cnt_next = heap_cnt_reg + HC_W'(1);
                        state_next    = S_SU_CHK;
                    end
                end
                else if (dir_reg == 2'd3)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    dir_next   = dir_reg + 2'd1;
                    state_next = S_NB;
                end
            end
            S_SU_CHK:
            begin
                if (idx_reg == '0)
                begin
                    state_next = S_SU_END;
                end
                else
                begin
                    hp_raddr   = (idx_reg - HA'(1)) >> 1;
                    child_next = (idx_reg - HA'(1)) >> 1;
                    state_next = S_SU_CMP;
                end
            end
            S_SU_CMP:
            begin
                if (hp_rdata <= key_reg)
                begin
                    state_next = S_SU_END;
                end
                else
                begin
                    hp_we      = 1'b1;
                    hp_wdata   = hp_rdata;
                    idx_next   = child_reg;
                    state_next = S_SU_CHK;
                end
            end
            S_SU_END:
            begin
                hp_we = 1'b1;
                if (dir_reg == 2'd3)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    dir_next   = dir_reg + 2'd1;
                    state_next = S_NB;
                end
            end
            S_BT0:
            begin
                len_next   = LEN_W'(cm_cost) + LEN_W'(1);
                k_next     = LEN_W'(cm_cost) + LEN_W'(1);
                p_next     = t_cell_reg;
                state_next = S_BT1;
            end
            S_BT1:
            begin
                pa_we    = 1'b1;
                pa_waddr = CW'(k_reg - LEN_W'(1));
                k_next   = k_reg - LEN_W'(1);
                if ((p_reg == s_cell_reg) || (k_reg == LEN_W'(1)))
                begin
                    stored_len_next       = len_reg;
                    pend_next.path_length = gapp_pkg::PLEN_W'(len_reg);
                    state_next            = S_DONE;
                end
                else
                begin
                    cm_raddr   = p_reg;
                    state_next = S_BT2;
                end
            end
            S_BT2:
            begin
                p_next     = cm_came;
                state_next = S_BT1;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = pend_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_RST_CLR;
            clr_addr_reg   <= '0;
            gw_cfg_reg     <= gapp_pkg::GRID_REG_W'(64);
            gh_cfg_reg     <= gapp_pkg::GRID_REG_W'(64);
            stored_len_reg <= '0;
            heap_cnt_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            stored_len_reg <= stored_len_next;
            heap_cnt_reg   <= heap_cnt_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (cfg_valid)
            begin
                if (cfg_index == gapp_pkg::CFG_GRID_WIDTH)
                begin
                    gw_cfg_reg <= cfg_data;
                end
                else
                begin
                    gh_cfg_reg <= cfg_data;
                end
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        s_cell_reg <= s_cell_next;
        t_cell_reg <= t_cell_next;
        cur_reg    <= cur_next;
        cur_g_reg  <= cur_g_next;
        dir_reg    <= dir_next;
        nb_reg     <= nb_next;
        last_reg   <= last_next;
        cval_reg   <= cval_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        child_reg  <= child_next;
        k_reg      <= k_next;
        len_reg    <= len_next;
        p_reg      <= p_next;
        pend_reg   <= pend_next;
        rsp_reg    <= rsp_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    // Passability map, one bit per cell.
    gapp_ram #(.DATA_W(1), .ADDR_W(CW)) u_occ (
        .clk(clk), .we(occ_we), .waddr(occ_waddr), .wdata(occ_wdata),
        .raddr(occ_raddr), .rdata(occ_rdata)
    );

    // Best cost and predecessor of each cell.
    gapp_ram #(.DATA_W(CM_W), .ADDR_W(CW)) u_cost (
        .clk(clk), .we(cm_we), .waddr(cm_waddr), .wdata(cm_wdata),
        .raddr(cm_raddr), .rdata(cm_rdata)
    );

    // Open list kept as a binary min-heap of {f, g, cell} keys.
    gapp_ram #(.DATA_W(KEY_W), .ADDR_W(HA)) u_heap (
        .clk(clk), .we(hp_we), .waddr(hp_waddr), .wdata(hp_wdata),
        .raddr(hp_raddr), .rdata(hp_rdata)
    );

    // Stored path, start first.
    gapp_ram #(.DATA_W(CW), .ADDR_W(CW)) u_path (
        .clk(clk), .we(pa_we), .waddr(pa_waddr), .wdata(pa_wdata),
        .raddr(pa_raddr), .rdata(pa_rdata)
    );

    `ASSERT_IMPL(a_heap_bound, clk, rst_n, 1'b1, heap_cnt_reg <= HC_W'(HEAP_DEPTH))
    `ASSERT_IMPL(a_len_bound, clk, rst_n, 1'b1, stored_len_reg <= LEN_W'(CELLS))
    `ASSERT_NEXT(a_result_out, clk, rst_n, (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready), rsp_valid_reg && (state_reg == S_IDLE))
    `ASSERT_NEXT(a_fail_keeps, clk, rst_n, (state_reg == S_DONE) && (pend_reg.status != gapp_pkg::ST_OK), $stable(stored_len_reg))

endmodule
